### rtl/dms_pkg.sv
// Shared types, codes and arithmetic helpers for the dichotomous minimum search unit.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package dms_pkg;

   localparam int unsigned ITER_WIDTH = 21;
   localparam logic [ITER_WIDTH-1:0] ITERATION_LIMIT = ITER_WIDTH'(2000000);

   localparam int unsigned DELTA_WIDTH = 31;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned CSR_ADDR_WIDTH = 3;

   // Register index (byte address / 4)
   localparam logic REG_DELTA_SETTING = 1'b0;

   typedef enum logic {
      ACT_START = 1'b0,
      ACT_VALUE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      KIND_PROBE  = 2'd0,
      KIND_DONE   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_INTERVAL  = 2'd1,
      ERR_EPS       = 2'd2,
      ERR_ITER_LIM  = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_WAIT_Y   = 2'd1,
      PH_WAIT_Z   = 2'd2,
      PH_WAIT_MID = 2'd3
   } phase_type;

   typedef struct packed {
      logic               action;
      logic signed [31:0] lower_bound;
      logic signed [31:0] upper_bound;
      logic signed [31:0] tolerance;
      logic signed [31:0] function_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] point;
      logic signed [31:0] min_value;
      logic [1:0]         error_code;
   } rsp_type;

   // floor((x + y) / 2), exact
   function automatic logic signed [31:0] mid_floor(input logic signed [31:0] x,
                                                    input logic signed [31:0] y);
      logic [32:0] s;
      s = {x[31], x} + {y[31], y};
      return s[32:1];
   endfunction

   // m +/- d, saturated to the signed 32-bit range
   function automatic logic signed [31:0] offset_sat(input logic signed [31:0] m,
                                                     input logic [DELTA_WIDTH-1:0] d,
                                                     input logic down);
      logic [32:0] r;
      r = down ? ({m[31], m} - {2'b00, d}) : ({m[31], m} + {2'b00, d});
      if (r[32] != r[31]) begin
         return r[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return r[31:0];
   endfunction

   // hi - lo <= 2 * tol, exact
   function automatic logic narrow_enough(input logic signed [31:0] lo,
                                          input logic signed [31:0] hi,
                                          input logic signed [31:0] tol);
      logic signed [32:0] w;
      logic signed [32:0] t2;
      w  = {hi[31], hi} - {lo[31], lo};
      t2 = {tol, 1'b0};
      return w <= t2;
   endfunction

endpackage

`default_nettype wire

### rtl/dms_csr.sv
// Configuration register block: APB-style slave holding delta_setting.
// Depends on dms_pkg.
`default_nettype none

module dms_csr
   import dms_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output      logic [CSR_DATA_WIDTH-1:0] prdata,
   output      logic                      pready,
   output      logic [DELTA_WIDTH-1:0]    delta_setting
);

   logic                   reg_index;
   logic                   wr_en;
   logic [DELTA_WIDTH-1:0] delta_ff;
   logic [DELTA_WIDTH-1:0] delta_in;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_WIDTH-1];
   assign wr_en     = psel & penable & pwrite & pready;

   always_comb begin
      delta_in = delta_ff;
      if (wr_en && reg_index == REG_DELTA_SETTING) begin
         delta_in = pwdata[DELTA_WIDTH-1:0];
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_DELTA_SETTING: prdata = {1'b0, delta_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff <= '0;
      end else begin
         delta_ff <= delta_in;
      end
   end

   assign delta_setting = delta_ff;

endmodule

`default_nettype wire

### rtl/dms_engine.sv
// Search state and single-pass datapath: one accepted transaction updates the
// interval state and yields at most one result. Depends on dms_pkg.
`default_nettype none

module dms_engine
   import dms_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire req_type                req,
   input  wire logic [DELTA_WIDTH-1:0] delta_setting,
   output      logic                   res_push,
   output      rsp_type                res
);

   phase_type              phase_ff, phase_in;
   logic signed [31:0]     low_ff, low_in;
   logic signed [31:0]     high_ff, high_in;
   logic signed [31:0]     tol_ff, tol_in;
   logic [DELTA_WIDTH-1:0] delta_ff, delta_in;
   logic signed [31:0]     left_ff, left_in;
   logic [ITER_WIDTH-1:0]  iter_ff, iter_in;

   // start path
   logic                   bad_interval, bad_eps, start_narrow;
   logic [32:0]            width_s;
   logic [DELTA_WIDTH-1:0] d_pick, d_max, d_clamp;
   logic signed [31:0]     mid_start;

   // value path
   logic signed [31:0]     mid_cur, mid_upd, lo_upd, hi_upd, pt_minus, pt_plus;
   logic                   keep_left, upd_narrow, limit_hit;
   logic [ITER_WIDTH-1:0]  iter_inc;

   assign bad_interval = req.lower_bound >= req.upper_bound;
   assign bad_eps      = req.tolerance <= 32'sd0;
   assign start_narrow = narrow_enough(req.lower_bound, req.upper_bound, req.tolerance);
   assign width_s      = {req.upper_bound[31], req.upper_bound}
                       - {req.lower_bound[31], req.lower_bound};
   assign mid_start    = mid_floor(req.lower_bound, req.upper_bound);

   // eps > 0 here, so the shift is floor(eps/2); width > 0, so shift is floor(width/4)
   assign d_pick = (delta_setting != '0) ? delta_setting : req.tolerance[31:1];
   assign d_max  = width_s[32:2];

   always_comb begin
      d_clamp = (d_pick > d_max) ? d_max : d_pick;
      if (d_clamp == '0) begin
         d_clamp = DELTA_WIDTH'(1);
      end
   end

   assign mid_cur    = mid_floor(low_ff, high_ff);
   assign pt_minus   = offset_sat(mid_cur, delta_ff, 1'b1);
   assign pt_plus    = offset_sat(mid_cur, delta_ff, 1'b0);
   assign keep_left  = left_ff <= req.function_value;
   assign lo_upd     = keep_left ? low_ff : pt_minus;
   assign hi_upd     = keep_left ? pt_plus : high_ff;
   assign mid_upd    = mid_floor(lo_upd, hi_upd);
   assign upd_narrow = narrow_enough(lo_upd, hi_upd, tol_ff);
   assign iter_inc   = iter_ff + ITER_WIDTH'(1);
   assign limit_hit  = iter_inc > ITERATION_LIMIT;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req.action == ACT_START) begin
            if (bad_interval || bad_eps) begin
               phase_in = PH_IDLE;
            end else if (start_narrow) begin
               phase_in = PH_WAIT_MID;
            end else begin
               phase_in = PH_WAIT_Y;
            end
         end else begin
            unique case (phase_ff)
               PH_WAIT_Y: phase_in = PH_WAIT_Z;
               PH_WAIT_Z: begin
                  if (upd_narrow) begin
                     phase_in = PH_WAIT_MID;
                  end else if (limit_hit) begin
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_WAIT_Y;
                  end
               end
               PH_WAIT_MID: phase_in = PH_IDLE;
               default:     phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // datapath registers and result
   always_comb begin
      low_in   = low_ff;
      high_in  = high_ff;
      tol_in   = tol_ff;
      delta_in = delta_ff;
      left_in  = left_ff;
      iter_in  = iter_ff;
      res_push = 1'b0;
      res      = '{kind: KIND_PROBE, point: '0, min_value: '0, error_code: ERR_NONE};
      if (accept) begin
         if (req.action == ACT_START) begin
            res_push = 1'b1;
            if (bad_interval) begin
               res.kind       = KIND_ERROR;
               res.error_code = ERR_INTERVAL;
            end else if (bad_eps) begin
               res.kind       = KIND_ERROR;
               res.error_code = ERR_EPS;
            end else begin
               low_in  = req.lower_bound;
               high_in = req.upper_bound;
               tol_in  = req.tolerance;
               left_in = '0;
               iter_in = '0;
               if (start_narrow) begin
                  res.point = mid_start;
               end else begin
                  delta_in  = d_clamp;
                  res.point = offset_sat(mid_start, d_clamp, 1'b1);
               end
            end
         end else begin
            unique case (phase_ff)
               PH_WAIT_Y: begin
                  left_in   = req.function_value;
                  res_push  = 1'b1;
                  res.point = pt_plus;
               end
               PH_WAIT_Z: begin
                  low_in   = lo_upd;
                  high_in  = hi_upd;
                  res_push = 1'b1;
                  if (upd_narrow) begin
                     res.point = mid_upd;
                  end else begin
                     iter_in = iter_inc;
                     if (limit_hit) begin
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_ITER_LIM;
                     end else begin
                        res.point = offset_sat(mid_upd, delta_ff, 1'b1);
                     end
                  end
               end
               PH_WAIT_MID: begin
                  res_push      = 1'b1;
                  res.kind      = KIND_DONE;
                  res.point     = mid_cur;
                  res.min_value = req.function_value;
               end
               default: res_push = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         low_ff   <= '0;
         high_ff  <= '0;
         tol_ff   <= '0;
         delta_ff <= '0;
         left_ff  <= '0;
         iter_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         tol_ff   <= tol_in;
         delta_ff <= delta_in;
         left_ff  <= left_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

`default_nettype wire

### rtl/dms_out_buf.sv
// Result register plus one skid entry so the input side can hand over one more
// result while the receiver stalls. Depends on dms_pkg.
`default_nettype none

module dms_out_buf
   import dms_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output      logic    full,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    take;

   assign take = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

### rtl/dichotomy_min_search_unit.sv
// Top level of the dichotomous minimum search controller (signed Q16.16).
// Instantiates dms_csr, dms_engine and dms_out_buf; depends on dms_pkg.
//
// Usage:
//  - req channel (req_valid / req_stall / req_data): a start transaction carries
//    the interval [a,b] and eps; a value transaction returns f at the last
//    requested point. A value transaction while idle is dropped, no result.
//  - rsp channel (rsp_valid / rsp_stall / rsp_data): probe requests, the final
//    x_min with f_min, or an error code.
//  - APB-style port: register 0 (byte address 0) is delta_setting, the half
//    probe spacing; zero selects eps/2. Write it only while no search is active.
// Result path: a taken transaction's result is registered (result register or skid entry).
// Throughput: one transaction per cycle while req_stall is low; the whole update
//    (midpoint, interval shrink, width check, next probe point) is one combinational
//    pass from the request to the result register.
// Stall: a result register plus one skid entry follow the datapath, so one
//    more transaction is taken while a result waits; req_stall rises only when
//    the skid entry is occupied, and clears as soon as the receiver takes one.
// Reset: synchronous, active high. Phase goes idle, interval state and
//    delta_setting clear, any pending results are dropped.
`default_nettype none

module dichotomy_min_search_unit
   import dms_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,

   // request channel
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire req_type                   req_data,

   // result channel
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      rsp_type                   rsp_data,

   // configuration port
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output      logic [CSR_DATA_WIDTH-1:0] prdata,
   output      logic                      pready
);

   logic                   delta_setting;
   logic [DELTA_WIDTH-1:0] delta_cfg;
   logic                   req_accept;
   logic                   res_push;
   rsp_type                res;
   logic                   buf_full;

   // transaction taken whenever the skid entry is free
   assign req_stall  = buf_full;
   assign req_accept = req_valid & ~buf_full;

   dms_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .delta_setting (delta_cfg)
   );

   // nonzero spacing programmed (informational, mirrors the eps/2 fallback)
   assign delta_setting = |delta_cfg;

   dms_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .req           (req_data),
      .delta_setting (delta_setting ? delta_cfg : '0),
      .res_push      (res_push),
      .res           (res)
   );

   dms_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### dv/tb_dichotomy_min_search_unit.sv
// Self-checking testbench for dichotomy_min_search_unit: directed table, then random searches.
// Holds its own search predictor; depends on dms_pkg and the RTL under rtl/.
// Request channel and APB-style register port share one driving process; rsp_stall has its own.
`timescale 1ns / 1ps

module tb_dichotomy_min_search_unit
   import dms_pkg::*;
();

   // Q16.16 corner values
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

   localparam logic [CSR_ADDR_WIDTH-1:0] DELTA_ADDR = {REG_DELTA_SETTING, 2'b00};

   localparam int ITEM_TARGET    = 1750;
   localparam int PHASES         = 6;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int IDLE_PERCENT   = 8;
   localparam int SETTLE_LIMIT   = 48;

   // One stimulus row: a request, plus an optional hand-typed result
   typedef struct {
      req_type item;
      bit      pinned;
      rsp_type rsp;
   } stim_row_type;

   logic                      clock   = 1'b0;
   logic                      reset   = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      psel    = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   dichotomy_min_search_unit u_top (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .psel,
      .penable,
      .pwrite,
      .paddr,
      .pwdata,
      .prdata,
      .pready
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Search predictor state: interval, tolerance, probe half-spacing, f(y),
   // current phase, iteration count and the delta_setting register copy.
   // ---------------------------------------------------------------------------
   logic signed [31:0]   lo_q     = '0;
   logic signed [31:0]   hi_q     = '0;
   logic signed [31:0]   eps_q    = '0;
   logic signed [31:0]   step_q   = '0;
   logic signed [31:0]   fy_q     = '0;
   phase_type            phase_q  = PH_IDLE;
   logic [ITER_WIDTH-1:0] iters_q = '0;
   logic [DELTA_WIDTH-1:0] delta_reg_q = '0;

   rsp_type      outstanding_rsp[$];   // results still owed by the block
   stim_row_type in_flight_rows[$];    // rows driven but not yet taken

   int  reqs_issued    = 0;
   int  reqs_taken     = 0;
   int  answered_items = 0;         // taken requests that owe a result
   int  mismatches     = 0;
   int  idle_cycles    = 0;
   bit  no_idle        = 1'b0;      // burst mode: no gaps, no stalls
   logic signed [31:0] last_fvalue = '0;

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return S_MAX;
      if (v < -64'sd2147483648) return S_MIN;
      return v[31:0];
   endfunction

   // floor((lo + hi) / 2), computed wide so nothing wraps
   function automatic longint mid_point();
      return (longint'(lo_q) + longint'(hi_q)) >>> 1;
   endfunction

   function automatic bit interval_closed();
      return (longint'(hi_q) - longint'(lo_q)) <= 2 * longint'(eps_q);
   endfunction

   task automatic step_search(input req_type r, output bit produced, output rsp_type res);
      logic signed [31:0] a_v;
      logic signed [31:0] b_v;
      logic signed [31:0] e_v;
      logic signed [31:0] f_v;
      longint width_l;
      longint d_l;
      longint m_l;
      a_v = r.lower_bound;
      b_v = r.upper_bound;
      e_v = r.tolerance;
      f_v = r.function_value;
      produced = 1'b1;
      res = '0;
      res.kind = KIND_PROBE;
      res.error_code = ERR_NONE;
      if (r.action == ACT_START) begin
         // a start always aborts whatever search is running
         if (a_v >= b_v) begin
            phase_q = PH_IDLE;
            res.kind = KIND_ERROR;
            res.error_code = ERR_INTERVAL;
         end else if (e_v <= 0) begin
            phase_q = PH_IDLE;
            res.kind = KIND_ERROR;
            res.error_code = ERR_EPS;
         end else begin
            lo_q = a_v;
            hi_q = b_v;
            eps_q = e_v;
            fy_q = '0;
            iters_q = '0;
            if (interval_closed()) begin
               phase_q = PH_WAIT_MID;
               res.point = clip32(mid_point());
            end else begin
               width_l = longint'(b_v) - longint'(a_v);
               if (delta_reg_q != '0) d_l = longint'(delta_reg_q);
               else d_l = longint'(e_v) / 2;
               // upper clamp first, then the 1 LSB floor wins
               if (d_l > width_l / 4) d_l = width_l / 4;
               if (d_l < 1) d_l = 1;
               step_q = d_l[31:0];
               phase_q = PH_WAIT_Y;
               res.point = clip32(mid_point() - longint'(step_q));
            end
         end
      end else begin
         case (phase_q)
            PH_WAIT_Y: begin
               fy_q = f_v;
               phase_q = PH_WAIT_Z;
               res.point = clip32(mid_point() + longint'(step_q));
            end
            PH_WAIT_Z: begin
               m_l = mid_point();
               if (fy_q <= f_v) hi_q = clip32(m_l + longint'(step_q));
               else lo_q = clip32(m_l - longint'(step_q));
               if (interval_closed()) begin
                  phase_q = PH_WAIT_MID;
                  res.point = clip32(mid_point());
               end else begin
                  iters_q = iters_q + 1'b1;
                  if (iters_q > ITERATION_LIMIT) begin
                     phase_q = PH_IDLE;
                     res.kind = KIND_ERROR;
                     res.error_code = ERR_ITER_LIM;
                  end else begin
                     phase_q = PH_WAIT_Y;
                     res.point = clip32(mid_point() - longint'(step_q));
                  end
               end
            end
            PH_WAIT_MID: begin
               phase_q = PH_IDLE;
               res.kind = KIND_DONE;
               res.point = clip32(mid_point());
               res.min_value = f_v;
            end
            default: produced = 1'b0;   // value while idle is dropped
         endcase
      end
   endtask

   task automatic flag_mismatch(input string msg);
      if (mismatches < 50) $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------
   // Directed table. Hand-typed results only where they are obvious: errors,
   // searches that start already narrow, and their final report.
   // ---------------------------------------------------------------------------
   stim_row_type directed_rows [25] = '{
      // value right after reset: no result
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, S_MAX}, 1'b0, '0},
      // empty interval
      '{'{ACT_START, 32'sd0, 32'sd0, Q_ONE, 32'sd0}, 1'b1,
        '{KIND_ERROR, 32'sd0, 32'sd0, ERR_INTERVAL}},
      // reversed interval and huge eps: interval checked first
      '{'{ACT_START, S_MAX, S_MIN, S_MAX, S_MIN}, 1'b1,
        '{KIND_ERROR, 32'sd0, 32'sd0, ERR_INTERVAL}},
      // full range, zero eps
      '{'{ACT_START, S_MIN, S_MAX, 32'sd0, 32'sd0}, 1'b1,
        '{KIND_ERROR, 32'sd0, 32'sd0, ERR_EPS}},
      // most negative eps
      '{'{ACT_START, -32'sd1, 32'sd1, S_MIN, 32'sd0}, 1'b1,
        '{KIND_ERROR, 32'sd0, 32'sd0, ERR_EPS}},
      // value after an error: dropped
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, S_MIN}, 1'b0, '0},
      // narrow from the start: straight to f(mid)
      '{'{ACT_START, 32'sd0, 32'sd2, 32'sd1, 32'sd0}, 1'b1,
        '{KIND_PROBE, 32'sd1, 32'sd0, ERR_NONE}},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, S_MIN}, 1'b1,
        '{KIND_DONE, 32'sd1, S_MIN, ERR_NONE}},
      // bottom of the range, midpoint floors to the minimum
      '{'{ACT_START, S_MIN, 32'sh8000_0001, 32'sd1, 32'sd0}, 1'b1,
        '{KIND_PROBE, S_MIN, 32'sd0, ERR_NONE}},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, S_MAX}, 1'b1,
        '{KIND_DONE, S_MIN, S_MAX, ERR_NONE}},
      // full range with the largest eps, equal values keep [a,z]
      '{'{ACT_START, S_MIN, S_MAX, S_MAX, 32'sd0}, 1'b0, '0},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, -32'sd5}, 1'b0, '0},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, -32'sd5}, 1'b0, '0},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, S_MAX}, 1'b0, '0},
      // width 3, eps 1: delta floors to 1 LSB, f(y)>f(z) leaves the interval as is
      '{'{ACT_START, 32'sd0, 32'sd3, 32'sd1, 32'sd0}, 1'b0, '0},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, 32'sd5}, 1'b0, '0},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, 32'sd1}, 1'b0, '0},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, 32'sd1}, 1'b0, '0},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, 32'sd1}, 1'b0, '0},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, 32'sd7}, 1'b0, '0},
      // start, then a second start that aborts it
      '{'{ACT_START, -32'sd262144, 32'sd262144, Q_ONE, 32'sd0}, 1'b0, '0},
      '{'{ACT_START, -32'sd1000, 32'sd1000, 32'sd10, 32'sd0}, 1'b0, '0},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, S_MIN}, 1'b0, '0},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, S_MAX}, 1'b0, '0},
      '{'{ACT_VALUE, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0}
   };

   // ---------------------------------------------------------------------------
   // Random requests. While a search runs, mostly values (rarely an aborting
   // start); while idle, mostly starts, most of them well formed.
   // ---------------------------------------------------------------------------
   function automatic req_type random_request();
      req_type            r;
      logic signed [31:0] swap_v;
      longint             eps_l;
      longint             width_l;
      longint             span_l;
      longint             a_l;
      longint             b_l;
      longint unsigned    pick64;
      int unsigned        roll;
      r.action         = ACT_VALUE;
      r.lower_bound    = $urandom;
      r.upper_bound    = $urandom;
      r.tolerance      = $urandom;
      r.function_value = $urandom;
      roll = $urandom_range(99);
      if ((phase_q == PH_IDLE) ? (roll < 94) : (roll < 4)) begin
         r.action = ACT_START;
         roll = $urandom_range(99);
         if (roll >= 6 && roll < 12) begin
            // force a >= b
            if (r.lower_bound < r.upper_bound) begin
               swap_v = r.lower_bound;
               r.lower_bound = r.upper_bound;
               r.upper_bound = swap_v;
            end
         end else if (roll >= 12) begin
            // well formed: width a modest multiple of eps, so searches end
            eps_l = longint'($urandom >> $urandom_range(1, 31));
            if (eps_l == 0) eps_l = 1;
            width_l = eps_l * longint'($urandom_range(1, 1 << $urandom_range(0, 12)));
            if (width_l > 64'sd4294967295)
               width_l = 64'sd4294967295 - longint'($urandom_range(0, 255));
            span_l = 64'sd4294967296 - width_l;
            pick64 = {$urandom, $urandom};
            a_l = -64'sd2147483648 + longint'(pick64 % span_l);
            b_l = a_l + width_l;
            r.lower_bound = a_l[31:0];
            r.upper_bound = b_l[31:0];
            r.tolerance   = eps_l[31:0];
            if (roll < 18) r.tolerance = (roll[0]) ? 32'sd0 : ~($urandom >> 1);
         end
      end else begin
         case ($urandom_range(7))
            0: r.function_value = last_fvalue;
            1: r.function_value = S_MIN;
            2: r.function_value = S_MAX;
            3: r.function_value = last_fvalue + 32'($urandom_range(0, 3));
            default: r.function_value = $urandom;
         endcase
         last_fvalue = r.function_value;
      end
      return r;
   endfunction

   // drive one request and wait until the monitor has taken it
   task automatic issue(input stim_row_type row);
      if (!no_idle && $urandom_range(99) < IDLE_PERCENT / 2) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      in_flight_rows.push_back(row);
      req_valid <= 1'b1;
      req_data  <= row.item;
      reqs_issued++;
      wait (reqs_taken == reqs_issued);
   endtask

   // feed values until the running search reports or fails; a search whose
   // spacing keeps it from closing is ended by an empty-interval start
   task automatic settle_search();
      stim_row_type row;
      int           sent;
      row.pinned = 1'b0;
      row.rsp    = '0;
      sent       = 0;
      while (phase_q != PH_IDLE) begin
         row.item = random_request();
         if (sent < SETTLE_LIMIT) begin
            row.item.action = ACT_VALUE;
         end else begin
            row.item.action      = ACT_START;
            row.item.lower_bound = '0;
            row.item.upper_bound = '0;
         end
         sent++;
         issue(row);
      end
   endtask

   // stop sending and let every owed result come back
   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write of delta_setting, then read it back
   task automatic program_delta(input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= DELTA_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      delta_reg_q = value[DELTA_WIDTH-1:0];
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[DELTA_WIDTH-1:0] !== delta_reg_q)
         flag_mismatch($sformatf("delta_setting read %h, want %h",
                                 prdata[DELTA_WIDTH-1:0], delta_reg_q));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // receiver stalls at random, except in burst mode
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
   end

   // ---------------------------------------------------------------------------
   // Monitor: predicts on every taken request, checks every taken result
   // against the oldest one owed.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_flow
      bit           produced;
      rsp_type      predicted;
      rsp_type      want;
      stim_row_type row;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            row = in_flight_rows.pop_front();
            step_search(req_data, produced, predicted);
            if (row.pinned) begin
               predicted = row.rsp;
               produced  = 1'b1;
            end
            if (produced) begin
               outstanding_rsp.push_back(predicted);
               answered_items++;
            end
            reqs_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (outstanding_rsp.size() == 0) begin
               flag_mismatch($sformatf("result kind %0d with nothing owed", rsp_data.kind));
            end else begin
               want = outstanding_rsp.pop_front();
               if (rsp_data.kind !== want.kind)
                  flag_mismatch($sformatf("kind %0d, want %0d", rsp_data.kind, want.kind));
               if (rsp_data.point !== want.point)
                  flag_mismatch($sformatf("point %0d, want %0d", rsp_data.point, want.point));
               if (rsp_data.min_value !== want.min_value)
                  flag_mismatch($sformatf("min_value %0d, want %0d",
                                          rsp_data.min_value, want.min_value));
               if (rsp_data.error_code !== want.error_code)
                  flag_mismatch($sformatf("error_code %0d, want %0d",
                                          rsp_data.error_code, want.error_code));
            end
         end
      end
   end

   // watchdog: too long with no transaction on any port ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence: reset, directed table at the reset delta, then random
   // phases, each with its own delta_setting (extremes included).
   // ---------------------------------------------------------------------------
   initial begin : run
      logic [31:0]  delta_plan [PHASES];
      stim_row_type row;
      delta_plan[0] = 32'd1;
      delta_plan[1] = 32'hFFFF_FFFF;          // top bit is dropped: max delta
      delta_plan[2] = 32'd0;                  // eps/2
      delta_plan[3] = $urandom_range(2, 32'h0002_0000);
      delta_plan[4] = $urandom;
      delta_plan[5] = 32'h7FFF_FFFE;
      row.pinned = 1'b0;
      row.rsp    = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) issue(directed_rows[i]);
      settle_search();

      for (int p = 0; p < PHASES; p++) begin
         drain();
         program_delta(delta_plan[p]);
         no_idle = (p == 2);
         while (answered_items < (p + 1) * ITEM_TARGET / PHASES) begin
            row.item = random_request();
            issue(row);
         end
         settle_search();
      end
      no_idle = 1'b0;

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
